// ===== hdl/spd_pkg.sv =====
package spd_pkg;

  // Operation codes of an input transaction
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Type byte codes following the header
  localparam logic [7:0] TYPE_HEARTBEAT = 8'h00;
  localparam logic [7:0] TYPE_PACKET    = 8'h01;

  // Heartbeat trailer byte
  localparam logic [7:0] HEARTBEAT_TAIL = 8'h00;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 1'b1;
  localparam logic [7:0] HEADER_FIRST_RST  = 8'h4E;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h52;

  // Header match progress codes
  localparam logic [1:0] HDR_NONE  = 2'd0;
  localparam logic [1:0] HDR_FIRST = 2'd1;
  localparam logic [1:0] HDR_BOTH  = 2'd2;

  // Heartbeat reply beat codes
  localparam logic [1:0] BEAT_FIRST  = 2'd0;
  localparam logic [1:0] BEAT_SECOND = 2'd1;
  localparam logic [1:0] BEAT_TAIL   = 2'd2;

  // Kind of result burst produced by one input transaction
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_STORE,
    KIND_TYPE,
    KIND_HEARTBEAT
  } kind_t;

  // Result burst handed from the framer to the output sequencer
  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_a;    // captured byte, or first header byte of a heartbeat
    logic [7:0] byte_b;    // second header byte of a heartbeat
    logic [7:0] index;     // index of the captured byte
    logic       complete;  // captured byte completes the packet
  } burst_t;

endpackage

// ===== hdl/spd_frame.sv =====
module spd_frame (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [7:0]                    in_rx_byte,
  // configuration writes
  input  logic                          cfg_valid,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  // result bursts
  output logic                          burst_valid,
  input  logic                          burst_ready,
  output spd_pkg::burst_t               burst
);

  logic       in_full_r;
  logic       op_r;
  logic [7:0] byte_r;

  logic [7:0] header_first_r;
  logic [7:0] header_second_r;

  logic [1:0] hdr_r, hdr_nxt;
  logic       capturing_r, capturing_nxt;
  logic       done_r, done_nxt;
  logic [7:0] widx_r, widx_nxt;
  logic [7:0] len_r, len_nxt;

  spd_pkg::burst_t burst_nxt;
  logic            take;

  // Consume the held transaction when it has no result or the sequencer takes it
  assign take        = in_full_r && ((burst_nxt.kind == spd_pkg::KIND_NONE) || burst_ready);
  assign in_ready    = !in_full_r || take;
  assign burst_valid = in_full_r && (burst_nxt.kind != spd_pkg::KIND_NONE);
  assign burst       = burst_nxt;

  // Hold the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full_r <= 1'b1;
    end else if (take) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      byte_r <= in_rx_byte;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= spd_pkg::HEADER_FIRST_RST;
      header_second_r <= spd_pkg::HEADER_SECOND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spd_pkg::CFG_HEADER_FIRST:  header_first_r  <= cfg_data;
        spd_pkg::CFG_HEADER_SECOND: header_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the held transaction into next framing state and a result burst
  always_comb begin
    hdr_nxt       = hdr_r;
    capturing_nxt = capturing_r;
    done_nxt      = done_r;
    widx_nxt      = widx_r;
    len_nxt       = len_r;
    burst_nxt     = '0;
    burst_nxt.kind = spd_pkg::KIND_NONE;

    if (op_r == spd_pkg::OP_RELEASE) begin
      done_nxt = 1'b0;
    end else if (done_r) begin
      // drop bytes until release
    end else if (capturing_r) begin
      if (widx_r == 8'd0) begin
        len_nxt = byte_r;
      end
      burst_nxt.kind     = spd_pkg::KIND_STORE;
      burst_nxt.byte_a   = byte_r;
      burst_nxt.index    = widx_r;
      burst_nxt.complete = (widx_r != 8'd0) && (widx_r == len_r);
      if (burst_nxt.complete) begin
        capturing_nxt = 1'b0;
        done_nxt      = 1'b1;
      end
      widx_nxt = widx_r + 8'd1;
    end else if ((hdr_r == spd_pkg::HDR_NONE) && (byte_r == header_first_r)) begin
      hdr_nxt = spd_pkg::HDR_FIRST;
    end else if ((hdr_r == spd_pkg::HDR_FIRST) && (byte_r == header_second_r)) begin
      hdr_nxt = spd_pkg::HDR_BOTH;
    end else if (hdr_r == spd_pkg::HDR_BOTH) begin
      hdr_nxt = spd_pkg::HDR_NONE;
      if (byte_r == spd_pkg::TYPE_HEARTBEAT) begin
        burst_nxt.kind   = spd_pkg::KIND_HEARTBEAT;
        burst_nxt.byte_a = header_first_r;
        burst_nxt.byte_b = header_second_r;
      end else begin
        if (byte_r == spd_pkg::TYPE_PACKET) begin
          widx_nxt      = 8'd0;
          capturing_nxt = 1'b1;
        end
        burst_nxt.kind = spd_pkg::KIND_TYPE;
      end
    end else begin
      // mismatch: restart header search
      hdr_nxt = spd_pkg::HDR_NONE;
    end
  end

  // Advance framing state when the transaction is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r       <= spd_pkg::HDR_NONE;
      capturing_r <= 1'b0;
      done_r      <= 1'b0;
      widx_r      <= 8'd0;
      len_r       <= 8'd0;
    end else if (take) begin
      hdr_r       <= hdr_nxt;
      capturing_r <= capturing_nxt;
      done_r      <= done_nxt;
      widx_r      <= widx_nxt;
      len_r       <= len_nxt;
    end
  end

endmodule

// ===== hdl/spd_tx_seq.sv =====
module spd_tx_seq (
  input  logic            clk,
  input  logic            rst_n,
  // result bursts
  input  logic            burst_valid,
  output logic            burst_ready,
  input  spd_pkg::burst_t burst,
  // result transactions
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_tx_valid,
  output logic [7:0]      out_tx_byte,
  output logic            out_store_valid,
  output logic [7:0]      out_store_index,
  output logic [7:0]      out_store_byte,
  output logic            out_package_complete,
  output logic            out_failsafe_reset,
  output logic            out_last
);

  logic            busy_r;
  spd_pkg::burst_t burst_r;
  logic [1:0]      beat_r;
  logic            fire;
  logic            last_beat;

  assign fire      = busy_r && out_ready;
  assign last_beat = (burst_r.kind != spd_pkg::KIND_HEARTBEAT) ||
                     (beat_r == spd_pkg::BEAT_TAIL);
  assign burst_ready = !busy_r || (fire && last_beat);
  assign out_valid   = busy_r;

  // Load a new burst or step through the heartbeat beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= spd_pkg::BEAT_FIRST;
    end else if (burst_valid && burst_ready) begin
      busy_r <= 1'b1;
      beat_r <= spd_pkg::BEAT_FIRST;
    end else if (fire) begin
      if (last_beat) begin
        busy_r <= 1'b0;
      end else begin
        beat_r <= beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid && burst_ready) begin
      burst_r <= burst;
    end
  end

  // Drive the result fields for the current beat
  always_comb begin
    out_tx_valid         = 1'b0;
    out_tx_byte          = 8'd0;
    out_store_valid      = 1'b0;
    out_store_index      = 8'd0;
    out_store_byte       = 8'd0;
    out_package_complete = 1'b0;
    out_failsafe_reset   = 1'b0;
    out_last             = last_beat;
    unique case (burst_r.kind)
      spd_pkg::KIND_STORE: begin
        out_store_valid      = 1'b1;
        out_store_index      = burst_r.index;
        out_store_byte       = burst_r.byte_a;
        out_package_complete = burst_r.complete;
      end
      spd_pkg::KIND_TYPE: begin
        out_failsafe_reset = 1'b1;
      end
      spd_pkg::KIND_HEARTBEAT: begin
        out_tx_valid       = 1'b1;
        out_failsafe_reset = (beat_r == spd_pkg::BEAT_FIRST);
        case (beat_r)
          spd_pkg::BEAT_FIRST:  out_tx_byte = burst_r.byte_a;
          spd_pkg::BEAT_SECOND: out_tx_byte = burst_r.byte_b;
          default:              out_tx_byte = spd_pkg::HEARTBEAT_TAIL;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/serial_packet_deframer_top.sv =====
// Serial packet deframer: takes received bytes (in_operation = 0) or a release
// command (in_operation = 1), finds the two configurable header bytes and the
// type byte, and reports a heartbeat reply (three results), a fail-safe pulse,
// or one result per captured packet byte with its index. A transaction enters
// an input register, is decoded combinationally and is registered in an
// output sequencer that drives the result. Captured bytes and type bytes
// sustain one transaction per cycle while the result channel is ready; a
// heartbeat holds the sequencer until its three reply bytes are taken. A
// transaction with no result (header bytes, dropped bytes, releases) is taken
// without waiting on the output. Configuration writes are always accepted
// (cfg_ready is high) and must only be issued while the block is idle.
module serial_packet_deframer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [7:0]                    in_rx_byte,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_tx_valid,
  output logic [7:0]                    out_tx_byte,
  output logic                          out_store_valid,
  output logic [7:0]                    out_store_index,
  output logic [7:0]                    out_store_byte,
  output logic                          out_package_complete,
  output logic                          out_failsafe_reset,
  output logic                          out_last
);

  logic            burst_valid;
  logic            burst_ready;
  spd_pkg::burst_t burst;

  assign cfg_ready = 1'b1;

  spd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_rx_byte  (in_rx_byte),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  spd_tx_seq u_tx_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .burst_valid         (burst_valid),
    .burst_ready         (burst_ready),
    .burst               (burst),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_store_valid     (out_store_valid),
    .out_store_index     (out_store_index),
    .out_store_byte      (out_store_byte),
    .out_package_complete(out_package_complete),
    .out_failsafe_reset  (out_failsafe_reset),
    .out_last            (out_last)
  );

endmodule

// ===== hdl/spd_checker.sv =====
module spd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_store_valid,
  input logic [7:0] out_store_index,
  input logic       out_package_complete,
  input logic       out_failsafe_reset,
  input logic       out_last
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) &&
      $stable(out_store_index) && $stable(out_last))
    else $error("result changed while stalled");

  // A result is either a reply byte or a captured byte, never both
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tx_valid && out_store_valid))
    else $error("reply and capture in one result");

  // Captured bytes are single-result transactions
  a_store_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_valid |-> out_last)
    else $error("captured byte not marked last");

  // Completion only on a captured byte past the length byte
  a_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_package_complete |-> out_store_valid && (out_store_index != 8'd0))
    else $error("bad packet completion");

  // First heartbeat byte carries the fail-safe pulse and is never the last
  a_hb_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid && out_failsafe_reset |-> !out_last)
    else $error("heartbeat reply cut short");

endmodule

bind serial_packet_deframer_top spd_checker u_spd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_tx_valid        (out_tx_valid),
  .out_tx_byte         (out_tx_byte),
  .out_store_valid     (out_store_valid),
  .out_store_index     (out_store_index),
  .out_package_complete(out_package_complete),
  .out_failsafe_reset  (out_failsafe_reset),
  .out_last            (out_last)
);

// ===== verif/tb_top.sv =====
module tb_top;

  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       package_complete;
    logic       failsafe_reset;
    logic       last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = spd_pkg::OP_BYTE;
  logic [7:0] in_rx_byte = 8'h00;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index = spd_pkg::CFG_HEADER_FIRST;
  logic [7:0] cfg_data = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_tx_valid;
  logic [7:0] out_tx_byte;
  logic out_store_valid;
  logic [7:0] out_store_index;
  logic [7:0] out_store_byte;
  logic out_package_complete;
  logic out_failsafe_reset;
  logic out_last;

  // Stimulus side
  rx_item_t rx_items[$];
  int queued_cnt = 0;
  int accepted_cnt = 0;
  bit calm = 1'b0;
  bit in_fire = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  logic [7:0] cur_first = spd_pkg::HEADER_FIRST_RST;
  logic [7:0] cur_second = spd_pkg::HEADER_SECOND_RST;

  // Deframer prediction state
  logic [7:0] hdr_first_q = spd_pkg::HEADER_FIRST_RST;
  logic [7:0] hdr_second_q = spd_pkg::HEADER_SECOND_RST;
  logic [1:0] hdr_match = spd_pkg::HDR_NONE;
  logic in_capture = 1'b0;
  logic pkt_held = 1'b0;
  logic [7:0] cap_index = 8'h00;
  logic [7:0] pkt_len = 8'h00;
  reply_t expected_replies[$];

  bit failed = 1'b0;
  int idle_cycles = 0;

  serial_packet_deframer_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_rx_byte(in_rx_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tx_valid(out_tx_valid),
    .out_tx_byte(out_tx_byte),
    .out_store_valid(out_store_valid),
    .out_store_index(out_store_index),
    .out_store_byte(out_store_byte),
    .out_package_complete(out_package_complete),
    .out_failsafe_reset(out_failsafe_reset),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Advance the deframer state by one transaction and queue its results
  function automatic void predict_deframe(input logic op, input logic [7:0] b);
    reply_t r;
    logic done;
    r = '0;
    if (op == spd_pkg::OP_RELEASE) begin
      pkt_held = 1'b0;
      return;
    end
    if (pkt_held)
      return;
    if (in_capture) begin
      if (cap_index == 8'h00)
        pkt_len = b;
      done = (cap_index != 8'h00) && (cap_index == pkt_len);
      r.store_valid = 1'b1;
      r.store_index = cap_index;
      r.store_byte = b;
      r.package_complete = done;
      r.last = 1'b1;
      expected_replies.push_back(r);
      if (done) begin
        in_capture = 1'b0;
        pkt_held = 1'b1;
      end
      cap_index = cap_index + 8'd1;
    end else if (hdr_match == spd_pkg::HDR_NONE && b == hdr_first_q) begin
      hdr_match = spd_pkg::HDR_FIRST;
    end else if (hdr_match == spd_pkg::HDR_FIRST && b == hdr_second_q) begin
      hdr_match = spd_pkg::HDR_BOTH;
    end else if (hdr_match == spd_pkg::HDR_BOTH) begin
      hdr_match = spd_pkg::HDR_NONE;
      if (b == spd_pkg::TYPE_HEARTBEAT) begin
        // Reply with the header and the tail byte
        r.tx_valid = 1'b1;
        r.tx_byte = hdr_first_q;
        r.failsafe_reset = 1'b1;
        expected_replies.push_back(r);
        r.failsafe_reset = 1'b0;
        r.tx_byte = hdr_second_q;
        expected_replies.push_back(r);
        r.tx_byte = spd_pkg::HEARTBEAT_TAIL;
        r.last = 1'b1;
        expected_replies.push_back(r);
      end else begin
        if (b == spd_pkg::TYPE_PACKET) begin
          cap_index = 8'h00;
          in_capture = 1'b1;
        end
        r.failsafe_reset = 1'b1;
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
    end else begin
      hdr_match = spd_pkg::HDR_NONE;
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [7:0] exp_v,
                                    input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // Sample transactions, predict, check, and watch for a hang
  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      in_fire = in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          spd_pkg::CFG_HEADER_FIRST:  hdr_first_q = cfg_data;
          spd_pkg::CFG_HEADER_SECOND: hdr_second_q = cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        predict_deframe(in_operation, in_rx_byte);
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result with no expectation pending");
          failed = 1'b1;
        end else begin
          want = expected_replies.pop_front();
          cmp_field("tx_valid", 8'(want.tx_valid), 8'(out_tx_valid));
          cmp_field("tx_byte", want.tx_byte, out_tx_byte);
          cmp_field("store_valid", 8'(want.store_valid), 8'(out_store_valid));
          cmp_field("store_index", want.store_index, out_store_index);
          cmp_field("store_byte", want.store_byte, out_store_byte);
          cmp_field("package_complete", 8'(want.package_complete),
                    8'(out_package_complete));
          cmp_field("failsafe_reset", 8'(want.failsafe_reset), 8'(out_failsafe_reset));
          cmp_field("last", 8'(want.last), 8'(out_last));
        end
      end
      if (in_fire || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[serial_packet_deframer_top] ERROR");
        $finish;
      end
    end
  end

  // Drive input transactions with random idle bursts
  always @(negedge clk) begin
    rx_item_t itm;
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (rx_items.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (rx_items.size() > 0) begin
        itm = rx_items.pop_front();
        in_valid <= 1'b1;
        in_operation <= itm.op;
        in_rx_byte <= itm.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void queue_byte(input logic [7:0] b);
    rx_items.push_back('{op: spd_pkg::OP_BYTE, data: b});
    queued_cnt++;
  endfunction

  function automatic void queue_release();
    rx_items.push_back('{op: spd_pkg::OP_RELEASE, data: 8'($urandom)});
    queued_cnt++;
  endfunction

  function automatic void queue_header();
    queue_byte(cur_first);
    queue_byte(cur_second);
  endfunction

  // Mostly well-formed frames with random content, some noise
  function automatic void queue_traffic(input int n);
    int cnt;
    int len;
    int k;
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
          queue_header();
          queue_byte(spd_pkg::TYPE_PACKET);
          queue_byte(8'(len));
          repeat (len) queue_byte(8'($urandom));
          k = $urandom_range(0, 2);
          repeat (k) queue_byte(8'($urandom));
          queue_release();
          cnt += len + 5;
        end
        3, 4: begin
          queue_header();
          queue_byte(spd_pkg::TYPE_HEARTBEAT);
          cnt += 3;
        end
        5: begin
          queue_header();
          queue_byte(8'($urandom_range(2, 255)));
          cnt += 3;
        end
        6: begin
          queue_byte(cur_first);
          queue_byte(8'($urandom));
          cnt += 2;
        end
        7: begin
          queue_release();
          cnt += 1;
        end
        default: begin
          k = $urandom_range(1, 3);
          repeat (k) queue_byte(8'($urandom));
          cnt += k;
        end
      endcase
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != queued_cnt || expected_replies.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_headers(input logic [7:0] first_b, input logic [7:0] second_b);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= spd_pkg::CFG_HEADER_FIRST;
    cfg_data <= first_b;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= spd_pkg::CFG_HEADER_SECOND;
    cfg_data <= second_b;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_first = first_b;
    cur_second = second_b;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames with the reset header
    queue_release();
    queue_header();
    queue_byte(spd_pkg::TYPE_HEARTBEAT);
    queue_byte(cur_first);
    queue_byte(cur_first);
    queue_byte(cur_second);
    queue_header();
    queue_byte(8'hFF);
    queue_header();
    queue_byte(spd_pkg::TYPE_PACKET);
    queue_byte(8'h02);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(cur_first);
    queue_release();
    queue_header();
    queue_byte(8'h02);
    queue_header();
    queue_byte(spd_pkg::TYPE_PACKET);
    queue_byte(8'h01);
    queue_byte(8'hAB);
    queue_release();
    wait_idle();

    // Extreme header values
    write_headers(8'h00, 8'hFF);
    queue_traffic(20);
    wait_idle();
    write_headers(8'hFF, 8'h00);
    queue_traffic(20);
    wait_idle();

    // Equal header bytes
    write_headers(8'h5A, 8'h5A);
    queue_traffic(15);
    wait_idle();

    // Random header, no idling on either side
    write_headers(8'($urandom), 8'($urandom));
    calm = 1'b1;
    queue_traffic(20);
    wait_idle();

    if (!failed)
      $display("[serial_packet_deframer_top] OK");
    else
      $display("[serial_packet_deframer_top] ERROR");
    $finish;
  end

endmodule
